### design/ehb_pkg.sv
// ----------------------------------------------------------------------------
// ehb_pkg
// Shared types, constants and codes for the energy histogram binner.
// ----------------------------------------------------------------------------
package ehb_pkg;

  // field widths
  localparam int unsigned EnergyW    = 32;
  localparam int unsigned BinWidthW  = 31;
  localparam int unsigned BinsInUseW = 11;
  localparam int unsigned BinFieldW  = 10;
  localparam int unsigned CountW     = 32;

  // configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CfgBinWidth = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBinsInUse = 2'd1;

  localparam logic [BinWidthW-1:0]  BinWidthReset  = 31'd256;
  localparam logic [BinsInUseW-1:0] BinsInUseReset = 11'd1024;

  localparam int unsigned MaxBinsDefault = 1024;

  // restoring divider, one quotient bit per cycle
  localparam int unsigned DivSteps = BinWidthW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_READ   = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_READ,
    ST_UPDATE,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic check;
    logic rd_en;
    logic update;
    logic out_load;
    logic clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_read;
    logic div_last;
    logic clr_last;
    logic oor;
    logic out_free;
  } ctrl_status_t;

endpackage

### design/ehb_ifs.sv
// ----------------------------------------------------------------------------
// ehb channel interfaces
// Valid/ready channels for items, results and configuration writes.
// ----------------------------------------------------------------------------
interface ehb_item_if;
  import ehb_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic signed [EnergyW-1:0]  energy;
  logic [BinFieldW-1:0]       read_bin;

  modport source (output valid, operation, energy, read_bin, input ready);
  modport sink (input valid, operation, energy, read_bin, output ready);
endinterface

interface ehb_result_if;
  import ehb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [BinFieldW-1:0] bin_number;
  logic [CountW-1:0]    bin_count;
  logic                 out_of_range;

  modport source (output valid, bin_number, bin_count, out_of_range, input ready);
  modport sink (input valid, bin_number, bin_count, out_of_range, output ready);
endinterface

interface ehb_cfg_if;
  import ehb_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### design/ehb_ram.sv
// ----------------------------------------------------------------------------
// ehb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ehb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/ehb_ctrl.sv
// ----------------------------------------------------------------------------
// ehb_ctrl
// Sequencer: clear sweep, divide, range check, counter read-modify-write.
// ----------------------------------------------------------------------------
module ehb_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  item_valid_i,
  output logic                  item_ready_o,
  input  ehb_pkg::ctrl_status_t status_i,
  output ehb_pkg::ctrl_cmd_t    cmd_o
);
  import ehb_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    item_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.in_read ? ST_CHECK : ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = status_i.oor ? ST_DONE : ST_READ;
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### design/ehb_datapath.sv
// ----------------------------------------------------------------------------
// ehb_datapath
// Config registers, restoring divider, range check, counter memory, output.
// ----------------------------------------------------------------------------
module ehb_datapath #(
  parameter int unsigned MaxBins = ehb_pkg::MaxBinsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ehb_pkg::ctrl_cmd_t                  cmd_i,
  output ehb_pkg::ctrl_status_t               status_o,
  input  logic                                item_operation_i,
  input  logic signed [ehb_pkg::EnergyW-1:0]  item_energy_i,
  input  logic [ehb_pkg::BinFieldW-1:0]       item_read_bin_i,
  input  logic                                cfg_write_i,
  input  logic [ehb_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [ehb_pkg::CfgDataW-1:0]        cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [ehb_pkg::BinFieldW-1:0]       out_bin_number_o,
  output logic [ehb_pkg::CountW-1:0]          out_bin_count_o,
  output logic                                out_of_range_o
);
  import ehb_pkg::*;

  localparam int unsigned AddrW = (MaxBins > 1) ? $clog2(MaxBins) : 1;
  localparam logic [31:0] MaxBinsW = 32'(MaxBins);

  // configuration
  logic [BinWidthW-1:0]  bin_width_q;
  logic [BinsInUseW-1:0] bins_in_use_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_width_q   <= BinWidthReset;
      bins_in_use_q <= BinsInUseReset;
    end else if (cfg_write_i) begin
      case (cfg_index_i)
        CfgBinWidth:  bin_width_q   <= cfg_data_i[BinWidthW-1:0];
        CfgBinsInUse: bins_in_use_q <= cfg_data_i[BinsInUseW-1:0];
        default: ;
      endcase
    end
  end

  // item capture and divider
  op_e                  op_q;
  logic                 sign_q;
  logic [BinFieldW-1:0] rbin_q;
  logic [BinWidthW-1:0] quo_q;
  logic [BinWidthW-1:0] rem_q;
  logic [DivCntW-1:0]   div_cnt_q;

  logic [BinWidthW:0]   trial;
  logic [BinWidthW:0]   divisor;
  logic [BinWidthW:0]   diff;
  logic                 fits;

  assign trial   = {rem_q, quo_q[BinWidthW-1]};
  assign divisor = {1'b0, bin_width_q};
  assign diff    = trial - divisor;
  assign fits    = (trial >= divisor);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_e'(item_operation_i);
      sign_q <= item_energy_i[EnergyW-1];
      rbin_q <= item_read_bin_i;
      quo_q  <= item_energy_i[BinWidthW-1:0];
      rem_q  <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= fits ? diff[BinWidthW-1:0] : trial[BinWidthW-1:0];
      quo_q <= {quo_q[BinWidthW-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.load) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  // range check
  logic [31:0] limit;
  logic        rec_oor;
  logic        rd_oor;
  logic        oor_now;

  assign limit   = (32'(bins_in_use_q) > MaxBinsW) ? MaxBinsW : 32'(bins_in_use_q);
  assign rec_oor = sign_q || (bin_width_q == '0) || ({1'b0, quo_q} >= limit);
  assign rd_oor  = (32'(rbin_q) >= MaxBinsW);
  assign oor_now = (op_q == OP_READ) ? rd_oor : rec_oor;

  logic                 oor_q;
  logic [AddrW-1:0]     addr_q;
  logic [BinFieldW-1:0] bin_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      oor_q  <= oor_now;
      addr_q <= (op_q == OP_READ) ? AddrW'(rbin_q) : AddrW'(quo_q);
      if (oor_now) begin
        bin_q <= '0;
      end else begin
        bin_q <= (op_q == OP_READ) ? rbin_q : quo_q[BinFieldW-1:0];
      end
    end
  end

  // clear sweep counter
  logic [AddrW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // counter memory
  logic [CountW-1:0] rdata;
  logic [CountW-1:0] inc;
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [CountW-1:0] ram_wdata;
  logic [CountW-1:0] count_q;

  assign inc       = (rdata == '1) ? rdata : rdata + 1'b1;
  assign ram_we    = cmd_i.clear || (cmd_i.update && (op_q == OP_RECORD));
  assign ram_waddr = cmd_i.clear ? clr_cnt_q : addr_q;
  assign ram_wdata = cmd_i.clear ? '0 : inc;

  ehb_ram #(
    .Width (CountW),
    .Depth (MaxBins)
  ) u_counts (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      count_q <= (op_q == OP_READ) ? rdata : inc;
    end
  end

  // output register
  logic                 out_valid_q;
  logic [BinFieldW-1:0] out_bin_q;
  logic [CountW-1:0]    out_count_q;
  logic                 out_oor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_bin_q   <= bin_q;
      out_count_q <= oor_q ? '0 : count_q;
      out_oor_q   <= oor_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_bin_number_o = out_bin_q;
  assign out_bin_count_o  = out_count_q;
  assign out_of_range_o   = out_oor_q;

  assign status_o.in_read  = (op_e'(item_operation_i) == OP_READ);
  assign status_o.div_last = (div_cnt_q == DivCntW'(DivSteps - 1));
  assign status_o.clr_last = (clr_cnt_q == AddrW'(MaxBins - 1));
  assign status_o.oor      = oor_now;
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule

### design/energy_histogram_binner_unit.sv
// ----------------------------------------------------------------------------
// energy_histogram_binner_unit
// Steps: a record word passes through the restoring divider, range check,
//   counter read, update and output load; a read word skips the divider.
//   Out-of-range records skip the memory.
// Throughput: one word at a time, set by the one-bit-per-cycle restoring
//   divider and the counter memory port, and stalled while a result waits.
// Reset: config returns to defaults, then a sweep over all MaxBins addresses
//   zeroes the counter memory while no word is taken (config writes still taken).
// ----------------------------------------------------------------------------
module energy_histogram_binner_unit #(
  parameter int unsigned MaxBins = ehb_pkg::MaxBinsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ehb_item_if.sink     item_i,
  ehb_result_if.source result_o,
  ehb_cfg_if.sink      cfg_i
);
  import ehb_pkg::*;

  // command and status between sequencer and datapath
  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // config writes are always taken and land at once; the sender keeps them
  // to times with no word in flight
  assign cfg_i.ready = 1'b1;

  // sequencer: owns the input handshake
  ehb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_i.valid),
    .item_ready_o (item_i.ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  // datapath: divider, range check, counter memory, output register
  ehb_datapath #(
    .MaxBins (MaxBins)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .item_operation_i (item_i.operation),
    .item_energy_i    (item_i.energy),
    .item_read_bin_i  (item_i.read_bin),
    .cfg_write_i      (cfg_i.valid),
    .cfg_index_i      (cfg_i.index),
    .cfg_data_i       (cfg_i.data),
    .out_valid_o      (result_o.valid),
    .out_ready_i      (result_o.ready),
    .out_bin_number_o (result_o.bin_number),
    .out_bin_count_o  (result_o.bin_count),
    .out_of_range_o   (result_o.out_of_range)
  );

endmodule

### tb/ehb_tally_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ehb_tally_checker
// Watches the item, result and config channels of the energy histogram
// binner. It keeps its own bin counters, predicts the result of every
// accepted item and checks each accepted result against the oldest one.
// ----------------------------------------------------------------------------
module ehb_tally_checker #(
  parameter int unsigned MaxBins = ehb_pkg::MaxBinsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ehb_item_if         item_mon,
  ehb_result_if       result_mon,
  ehb_cfg_if          cfg_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned oor_seen_o
);
  import ehb_pkg::*;

  typedef struct packed {
    logic [BinFieldW-1:0] bin_number;
    logic [CountW-1:0]    bin_count;
    logic                 out_of_range;
  } tally_t;

  tally_t               due_tallies[$];
  logic [CountW-1:0]    bin_tally[MaxBins];
  logic [BinWidthW-1:0] width_q;
  logic [BinsInUseW-1:0] bins_q;
  int unsigned          fails;
  int unsigned          checked;
  int unsigned          oor_seen;

  // result of one item; a record bumps its bin in the local counters
  function automatic tally_t next_tally(input op_e op,
                                        input logic [EnergyW-1:0] energy,
                                        input logic [BinFieldW-1:0] rbin);
    tally_t            r;
    int unsigned       limit;
    logic [EnergyW-1:0] q;
    r = '0;
    if (op == OP_READ) begin
      if (rbin < MaxBins) begin
        r.bin_number = rbin;
        r.bin_count  = bin_tally[rbin];
      end else begin
        r.out_of_range = 1'b1;
      end
      return r;
    end
    limit = (bins_q > MaxBins) ? MaxBins : bins_q;
    if (energy[EnergyW-1] || width_q == '0) begin
      r.out_of_range = 1'b1;
      return r;
    end
    q = energy / {1'b0, width_q};
    if (q >= limit) begin
      r.out_of_range = 1'b1;
      return r;
    end
    if (bin_tally[q] != '1) bin_tally[q] = bin_tally[q] + 1'b1;
    r.bin_number = q[BinFieldW-1:0];
    r.bin_count  = bin_tally[q];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tally_t due;
    tally_t seen;
    if (!rst_ni) begin
      for (int b = 0; b < MaxBins; b++) bin_tally[b] = '0;
      width_q = BinWidthReset;
      bins_q  = BinsInUseReset;
      due_tallies.delete();
      fails    = 0;
      checked  = 0;
      oor_seen = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CfgBinWidth:  width_q = cfg_mon.data[BinWidthW-1:0];
          CfgBinsInUse: bins_q  = cfg_mon.data[BinsInUseW-1:0];
          default: ;
        endcase
      end
      if (item_mon.valid && item_mon.ready) begin
        due_tallies.push_back(next_tally(op_e'(item_mon.operation), item_mon.energy,
                                         item_mon.read_bin));
      end
      if (result_mon.valid && result_mon.ready) begin
        seen = '{result_mon.bin_number, result_mon.bin_count, result_mon.out_of_range};
        if (seen.out_of_range) oor_seen++;
        if (due_tallies.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t unexpected result: bin %0d count %0d oor %0b", $time,
                     seen.bin_number, seen.bin_count, seen.out_of_range);
        end else begin
          due = due_tallies.pop_front();
          checked++;
          if (seen.bin_number !== due.bin_number || seen.bin_count !== due.bin_count ||
              seen.out_of_range !== due.out_of_range) begin
            fails++;
            if (fails <= 10)
              $display("%0t mismatch: bin %0d/%0d count %0d/%0d oor %0b/%0b (exp/act)",
                       $time, due.bin_number, seen.bin_number, due.bin_count,
                       seen.bin_count, due.out_of_range, seen.out_of_range);
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= due_tallies.size();
    checked_o    <= checked;
    oor_seen_o   <= oor_seen;
  end

endmodule

### tb/energy_histogram_binner_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// energy_histogram_binner_unit_tb
// Drives record and read words into the histogram binner through six bin
// settings, with random gaps and result stalls; a checker beside the block
// predicts every result and counts failures for the verdict.
// ----------------------------------------------------------------------------
module energy_histogram_binner_unit_tb;
  import ehb_pkg::*;

  localparam int unsigned MaxBins    = MaxBinsDefault;
  localparam int unsigned CycleLimit = 400_000;
  // config indexes past the register list, written to show they do nothing
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;

  logic clk_i;
  logic rst_ni;

  ehb_item_if   item_ch ();
  ehb_result_if result_ch ();
  ehb_cfg_if    cfg_ch ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned oor_seen;

  // mirror of the config, only used to aim energies and reads at live bins
  logic [BinWidthW-1:0]  cur_width;
  logic [BinsInUseW-1:0] cur_bins;
  // set for the last phase: no gaps and no stalls at all
  logic        calm;
  int unsigned n_records;
  int unsigned n_reads;

  energy_histogram_binner_unit #(
    .MaxBins (MaxBins)
  ) i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_ch),
    .result_o (result_ch),
    .cfg_i    (cfg_ch)
  );

  ehb_tally_checker #(
    .MaxBins (MaxBins)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_mon     (item_ch),
    .result_mon   (result_ch),
    .cfg_mon      (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .oor_seen_o   (oor_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("CHECKS FAILED");
    $finish;
  end

  // result side: ready high for random stretches, dropped at random times unless calm
  initial begin
    forever begin
      result_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      if (!calm && $urandom_range(0, 2) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
    end
  end

  // one word; valid stays high after acceptance so words can go back to back
  task automatic send_word(input op_e op, input logic [EnergyW-1:0] energy,
                           input logic [BinFieldW-1:0] rbin);
    if (!calm && $urandom_range(0, 3) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    item_ch.valid     <= 1'b1;
    item_ch.operation <= op;
    item_ch.energy    <= energy;
    item_ch.read_bin  <= rbin;
    do @(posedge clk_i); while (!item_ch.ready);
    if (op == OP_RECORD) n_records++;
    else n_reads++;
  endtask

  // config write; valid is left high, the caller drops it after the last one
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      CfgBinWidth:  cur_width = data[BinWidthW-1:0];
      CfgBinsInUse: cur_bins  = data[BinsInUseW-1:0];
      default: ;
    endcase
  endtask

  initial begin
    int unsigned          words;
    int unsigned          lim;
    int unsigned          pick;
    longint               base;
    logic [EnergyW-1:0]   energy;
    logic [BinFieldW-1:0] rbin;

    // everything known from time zero
    rst_ni            <= 1'b0;
    item_ch.valid     <= 1'b0;
    item_ch.operation <= OP_RECORD;
    item_ch.energy    <= '0;
    item_ch.read_bin  <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= CfgBinWidth;
    cfg_ch.data       <= '0;
    cur_width = BinWidthReset;
    cur_bins  = BinsInUseReset;
    calm      = 1'b0;
    n_records = 0;
    n_reads   = 0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed words under the reset setting: width 1.0, all 1024 bins
    send_word(OP_RECORD, 32'h0000_0000, BinFieldW'($urandom));  // zero energy, bin 0
    send_word(OP_RECORD, 32'h0000_00FF, BinFieldW'($urandom));  // top of bin 0
    send_word(OP_RECORD, 32'h0000_0100, BinFieldW'($urandom));  // bin edge, bin 1
    send_word(OP_RECORD, 32'h0003_FFFF, BinFieldW'($urandom));  // last bin
    // first energy past the last bin
    send_word(OP_RECORD, 32'h0004_0000, BinFieldW'($urandom));
    send_word(OP_RECORD, 32'h7FFF_FFFF, BinFieldW'($urandom));  // largest positive energy
    send_word(OP_RECORD, 32'h8000_0000, BinFieldW'($urandom));  // most negative energy
    send_word(OP_RECORD, 32'hFFFF_FFFF, BinFieldW'($urandom));  // smallest negative energy
    send_word(OP_RECORD, 32'hFFFF_FF00, BinFieldW'($urandom));  // floor lands on -1
    send_word(OP_READ, $urandom, 10'd0);
    send_word(OP_READ, $urandom, 10'd1);
    send_word(OP_READ, $urandom, 10'd1023);
    send_word(OP_READ, $urandom, 10'd512);          // never touched
    send_word(OP_RECORD, 32'h0000_0080, BinFieldW'($urandom));
    send_word(OP_READ, 32'hFFFF_FFFF, 10'd0);

    for (int p = 0; p < 6; p++) begin
      // registers change only with nothing in flight
      if (p > 0) begin
        item_ch.valid <= 1'b0;
        do @(posedge clk_i); while (pending != 0);
      end
      case (p)
        0: words = 250;
        1: begin
          // narrowest bins, a single bin counted
          write_reg(CfgBinWidth, 32'd1);
          write_reg(CfgBinsInUse, 32'd1);
          words = 250;
        end
        2: begin
          // widest bin, top bit of the data dropped; bins in use clamped to the storage
          write_reg(CfgBinWidth, 32'hFFFF_FFFF);
          write_reg(CfgBinsInUse, 32'h0000_07FF);
          write_reg(CfgSpareLo, $urandom);
          words = 200;
        end
        3: begin
          // zero width and zero bins: every record is out of range
          write_reg(CfgBinWidth, 32'h0000_0000);
          write_reg(CfgBinsInUse, 32'hFFFF_F800);
          write_reg(CfgSpareHi, $urandom);
          words = 100;
        end
        4: begin
          write_reg(CfgBinWidth, {1'($urandom_range(0, 1)), 31'($urandom_range(1, 4096))});
          write_reg(CfgBinsInUse, {21'($urandom), 11'($urandom_range(1, 1024))});
          words = 400;
        end
        default: begin
          // 1.5 per bin, full table, no idling
          write_reg(CfgBinWidth, 32'd384);
          write_reg(CfgBinsInUse, 32'd1024);
          calm  = 1'b1;
          words = 450;
        end
      endcase
      cfg_ch.valid <= 1'b0;

      lim = (cur_bins > MaxBins) ? MaxBins : cur_bins;
      for (int k = 0; k < words; k++) begin
        if ($urandom_range(0, 9) < 3) begin
          // reads go to live bins half the time, else anywhere in the table
          if (lim > 0 && $urandom_range(0, 1) == 0)
            rbin = BinFieldW'($urandom_range(0, lim - 1));
          else rbin = BinFieldW'($urandom_range(0, MaxBins - 1));
          send_word(OP_READ, $urandom, rbin);
        end else begin
          pick = $urandom_range(0, 9);
          base = -1;
          if (cur_width != '0 && lim > 0) begin
            if (pick < 6)
              base = longint'($urandom_range(0, lim - 1)) * longint'(cur_width) +
                     longint'($urandom_range(0, cur_width - 1));
            else if (pick == 6)
              base = longint'($urandom_range(0, lim)) * longint'(cur_width);
            else if (pick == 7)
              base = longint'(lim) * longint'(cur_width) - 1 + $urandom_range(0, 2);
          end
          if (pick == 8) energy = $urandom;
          else if (pick == 9) energy = $urandom | 32'h8000_0000;
          else if (base < 0 || base > 64'h7FFF_FFFF) energy = $urandom_range(0, 32'h7FFF_FFFF);
          else energy = base[EnergyW-1:0];
          send_word(OP_RECORD, energy, BinFieldW'($urandom));
        end
      end
    end

    // drain, then leave room for any stray result
    item_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (40) @(posedge clk_i);

    $display("covered %0d record and %0d read words over six bin settings", n_records,
             n_reads);
    $display("%0d results compared, %0d flagged out of range", checked, oor_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
design/ehb_pkg.sv
design/ehb_ifs.sv
design/ehb_ram.sv
design/ehb_ctrl.sv
design/ehb_datapath.sv
design/energy_histogram_binner_unit.sv
tb/ehb_tally_checker.sv
tb/energy_histogram_binner_unit_tb.sv
